[rtl/msb_first_bit_packer_top_assert.svh]
// Assertion macros shared by the bit packer RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef MSB_FIRST_BIT_PACKER_TOP_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_TOP_ASSERT_SVH
`ifndef SYNTH
// Checks that a condition holds at every clock edge outside reset.
`define MBP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: condition does not hold");
// Checks that a condition implies a consequence in the same cycle.
`define MBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
// Checks that a condition implies a consequence in the next cycle.
`define MBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");
`else
`define MBP_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define MBP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/mbp_pkg.sv]
// Package of the MSB-first bit packer: operation codes, widths and the job type.
// No dependencies; used by the top level, front end, queue and back end.
package mbp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned LenW    = 6;
  localparam int unsigned CntW    = 3;
  localparam int unsigned NbW     = 3;
  localparam int unsigned AccW    = ValueW + ByteW;
  localparam logic [LenW-1:0] MaxLen = 6'd32;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_ALIGN_ZERO = 2'd1,
    OP_STOP_ALIGN = 2'd2
  } op_e;

  // One queued job: up to four finished bytes, first byte in the top lane.
  typedef struct packed {
    logic [ValueW-1:0] bytes;
    logic [NbW-1:0]    nbytes;
  } job_t;

endpackage

[rtl/mbp_if.sv]
// Channel interfaces of the bit packer: code words in, stream bytes out.
// Depends on nothing; used by the top level, the front end and the back end.
interface mbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] code_value;
  logic [5:0]  code_length;

  modport source (output valid, op, code_value, code_length, input ready);
  modport sink   (input valid, op, code_value, code_length, output ready);
endinterface

interface mbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic [31:0] bits_emitted;

  modport source (output valid, out_byte, last_of_run, bits_emitted, input ready);
  modport sink   (input valid, out_byte, last_of_run, bits_emitted, output ready);
endinterface

[rtl/msb_first_bit_packer_top.sv]
// Top level of the MSB-first bit packer: front end, job queue and back end.
// Depends on mbp_pkg, mbp_if, mbp_front, mbp_queue and mbp_back.
//
//   channel  | dir | word                                   | handshake
//   ---------+-----+----------------------------------------+-------------
//   in_i     | in  | op, code_value, code_length            | valid/ready
//   out_o    | out | out_byte, last_of_run, bits_emitted    | valid/ready
//
// A code word is taken whenever the two-entry job queue has room; the back end then
// sends the bytes it completes (0 to 4) one per cycle while out_o.ready is high, so
// the single byte output register sets the rate. The first byte of a word is held in
// the job queue and then in the output register before it is valid.
// Reset clears the held bits, the queue and the emitted bit count.
// An output stall fills the queue and then holds in_i.ready low.
module msb_first_bit_packer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbp_in_if.sink     in_i,
  mbp_out_if.source  out_o
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  mbp_pkg::job_t job;
  mbp_pkg::job_t head;

  mbp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job)
  );

  mbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  mbp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[rtl/mbp_front.sv]
// Front end: accepts code words, merges them with the held partial byte and
// turns finished bytes into jobs. Depends on mbp_pkg, mbp_if and the assert header.
`include "msb_first_bit_packer_top_assert.svh"
module mbp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  mbp_in_if.sink             in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output mbp_pkg::job_t      job_o
);

  logic [mbp_pkg::ByteW-1:0]  pend_bits_q, pend_bits_d;
  logic [mbp_pkg::CntW-1:0]   pend_cnt_q, pend_cnt_d;
  logic [mbp_pkg::LenW-1:0]   len_sat;
  logic [mbp_pkg::LenW-1:0]   total;
  logic [mbp_pkg::AccW-1:0]   shifted;
  logic [mbp_pkg::AccW-1:0]   acc;
  logic [mbp_pkg::ByteW-1:0]  stop_byte;
  logic [mbp_pkg::NbW-1:0]    wr_nb;
  logic [mbp_pkg::ByteW-1:0]  wr_pend;
  logic                       accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Saturate the length and left-align the code bits; bits above the length drop out.
  assign len_sat = (in_i.code_length > mbp_pkg::MaxLen) ? mbp_pkg::MaxLen : in_i.code_length;
  assign shifted = {in_i.code_value, {mbp_pkg::ByteW{1'b0}}} << (mbp_pkg::MaxLen - len_sat);

  // Place the code right behind the held bits.
  assign acc   = {pend_bits_q, {mbp_pkg::ValueW{1'b0}}} | (shifted >> pend_cnt_q);
  assign total = {{(mbp_pkg::LenW - mbp_pkg::CntW){1'b0}}, pend_cnt_q} + len_sat;
  assign wr_nb = total[mbp_pkg::LenW-1:mbp_pkg::CntW];

  // The byte after the finished ones holds the remaining bits, zero below.
  always_comb begin
    case (wr_nb)
      3'd0:    wr_pend = acc[39:32];
      3'd1:    wr_pend = acc[31:24];
      3'd2:    wr_pend = acc[23:16];
      3'd3:    wr_pend = acc[15:8];
      default: wr_pend = acc[7:0];
    endcase
  end

  // A stop bit always closes exactly one byte.
  assign stop_byte = pend_bits_q | (8'h80 >> pend_cnt_q);

  // Classify the word and build the job.
  always_comb begin
    pend_bits_d  = pend_bits_q;
    pend_cnt_d   = pend_cnt_q;
    job_o.bytes  = acc[mbp_pkg::AccW-1:mbp_pkg::ByteW];
    job_o.nbytes = '0;
    case (in_i.op)
      mbp_pkg::OP_WRITE: begin
        job_o.nbytes = wr_nb;
        pend_bits_d  = wr_pend;
        pend_cnt_d   = total[mbp_pkg::CntW-1:0];
      end
      mbp_pkg::OP_ALIGN_ZERO: begin
        job_o.bytes  = {pend_bits_q, 24'h0};
        job_o.nbytes = (pend_cnt_q != '0) ? 3'd1 : 3'd0;
        pend_bits_d  = '0;
        pend_cnt_d   = '0;
      end
      mbp_pkg::OP_STOP_ALIGN: begin
        job_o.bytes  = {stop_byte, 24'h0};
        job_o.nbytes = 3'd1;
        pend_bits_d  = '0;
        pend_cnt_d   = '0;
      end
      default: begin
        job_o.nbytes = '0;
      end
    endcase
  end

  assign push_o = accept && (job_o.nbytes != '0);

  // Held partial byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (accept) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  // A pushed job carries one to four bytes, and bits below the held ones stay clear.
  `MBP_ASSERT_IMPL(a_job_size, clk_i, rst_ni, push_o, job_o.nbytes <= 3'd4)
  `MBP_ASSERT_ALWAYS(a_pend_clean, clk_i, rst_ni, (pend_bits_q & (8'hFF >> pend_cnt_q)) == 8'h00)

endmodule

[rtl/mbp_queue.sv]
// Two-entry job queue between the front and back ends.
// Depends on mbp_pkg and the assert header.
`include "msb_first_bit_packer_top_assert.svh"
module mbp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mbp_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mbp_pkg::job_t  head_o
);

  mbp_pkg::job_t entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // No push into a full queue, no pop from an empty one.
  `MBP_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, full_o, !push_i)
  `MBP_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, empty_o, !pop_i)

endmodule

[rtl/mbp_back.sv]
// Back end: sends the bytes of each job one per cycle unless stalled, through an output
// register and keeps the emitted bit count. Depends on mbp_pkg, mbp_if, assert header.
`include "msb_first_bit_packer_top_assert.svh"
module mbp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  mbp_pkg::job_t  head_i,
  output logic           pop_o,
  mbp_out_if.source      out_o
);

  logic [1:0]                  idx_q;
  logic                        out_valid_q;
  logic [mbp_pkg::ByteW-1:0]   out_byte_q;
  logic                        out_last_q;
  logic [mbp_pkg::ValueW-1:0]  bits_q;
  logic [mbp_pkg::ByteW-1:0]   sel_byte;
  logic                        sel_last;
  logic                        take;

  // Load the next byte when the output register is free or being drained.
  assign take     = !empty_i && (!out_valid_q || out_o.ready);
  assign sel_last = ({1'b0, idx_q} + 3'd1) == head_i.nbytes;
  assign pop_o    = take && sel_last;

  // Byte lane of the head job, first byte in the top lane.
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.bytes[31:24];
      2'd1:    sel_byte = head_i.bytes[23:16];
      2'd2:    sel_byte = head_i.bytes[15:8];
      default: sel_byte = head_i.bytes[7:0];
    endcase
  end

  // Byte index within the head job, output valid and bit count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      bits_q      <= '0;
    end else begin
      if (take) begin
        idx_q       <= sel_last ? 2'd0 : idx_q + 2'd1;
        out_valid_q <= 1'b1;
        bits_q      <= bits_q + 32'd8;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q <= sel_byte;
      out_last_q <= sel_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.last_of_run  = out_last_q;
  assign out_o.bits_emitted = bits_q;

  // Each loaded byte adds exactly eight to the count; the index stays inside its job.
  `MBP_ASSERT_NEXT(a_count_step, clk_i, rst_ni, take, bits_q == $past(bits_q) + 32'd8)
  `MBP_ASSERT_IMPL(a_idx_in_job, clk_i, rst_ni, !empty_i, {1'b0, idx_q} < head_i.nbytes)

endmodule
